// ===== src/ebf_pkg.sv =====
// Shared constants, types and the microcode program of the ECG baseline IIR filter.
package ebf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RESULT_W   = 32;
  localparam int TAP_W      = 32;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 16;
  localparam int HIST_W     = 40;
  localparam int BASE_W     = 33;
  localparam int COEF_W     = TAP_W + 1;
  localparam int OPND_W     = HIST_W - FRAC_W + 1;
  localparam int PROD_W     = COEF_W + OPND_W;
  localparam int ACC_W      = 74;
  localparam int BASE_LSB   = FRAC_W;
  localparam int BASE_MSB   = BASE_LSB + BASE_W - 1;
  localparam int Y_LSB      = 27;
  localparam int Y_MSB      = Y_LSB + HIST_W - 1;
  localparam int OUT_SH     = 8;
  localparam int STEP_W     = 5;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd22;

  localparam logic signed [TAP_W-1:0]  FF_TAP0_RST = 32'sd456340;
  localparam logic signed [TAP_W-1:0]  FF_TAP2_RST = -32'sd912681;
  localparam logic signed [TAP_W-1:0]  FF_TAP4_RST = 32'sd456340;
  localparam logic signed [TAP_W-1:0]  FB_TAP1_RST = -32'sd493773600;
  localparam logic signed [TAP_W-1:0]  FB_TAP2_RST = 32'sd695207566;
  localparam logic signed [TAP_W-1:0]  FB_TAP3_RST = -32'sd443696965;
  localparam logic signed [TAP_W-1:0]  FB_TAP4_RST = 32'sd108179489;
  localparam logic [WEIGHT_W-1:0]      WEIGHT_RST  = 16'd328;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FF_TAP0         = 3'd0,
    CFG_FF_TAP2         = 3'd1,
    CFG_FF_TAP4         = 3'd2,
    CFG_FB_TAP1         = 3'd3,
    CFG_FB_TAP2         = 3'd4,
    CFG_FB_TAP3         = 3'd5,
    CFG_FB_TAP4         = 3'd6,
    CFG_BASELINE_WEIGHT = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CSEL_WEIGHT, CSEL_B0, CSEL_B2, CSEL_B4, CSEL_A1, CSEL_A2, CSEL_A3, CSEL_A4
  } coef_sel_t;

  typedef enum logic [2:0] {
    SSEL_X, SSEL_XH1, SSEL_XH3, SSEL_YH0, SSEL_YH1, SSEL_YH2, SSEL_YH3
  } src_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_START, ACT_BASE, ACT_XLOAD, ACT_FINISH, ACT_EMIT
  } act_t;

  typedef enum logic [1:0] {
    HOLD_NONE, HOLD_IN, HOLD_OUT
  } hold_t;

  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef;
    src_sel_t  src;
    logic      part_hi;
    act_t      act;
    hold_t     hold;
    logic      last;
  } ctrl_t;

  localparam ctrl_t CW_NOP = '{
    mul_en: 1'b0, coef: CSEL_WEIGHT, src: SSEL_X, part_hi: 1'b0,
    act: ACT_NONE, hold: HOLD_NONE, last: 1'b0
  };

  function automatic ctrl_t mul_word(input coef_sel_t coef, input src_sel_t src,
                                     input logic part_hi);
    ctrl_t cw;
    cw         = CW_NOP;
    cw.mul_en  = 1'b1;
    cw.coef    = coef;
    cw.src     = src;
    cw.part_hi = part_hi;
    return cw;
  endfunction

  function automatic ctrl_t act_word(input act_t act, input hold_t hold, input logic last);
    ctrl_t cw;
    cw      = CW_NOP;
    cw.act  = act;
    cw.hold = hold;
    cw.last = last;
    return cw;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    unique case (step)
      5'd0:  cw = act_word(ACT_START, HOLD_IN, 1'b0);
      5'd1:  cw = mul_word(CSEL_WEIGHT, SSEL_X, 1'b0);
      5'd2:  cw = mul_word(CSEL_WEIGHT, SSEL_X, 1'b1);
      5'd3:  cw = CW_NOP;
      5'd4:  cw = act_word(ACT_BASE, HOLD_NONE, 1'b0);
      5'd5:  cw = act_word(ACT_XLOAD, HOLD_NONE, 1'b0);
      5'd6:  cw = mul_word(CSEL_B0, SSEL_X, 1'b0);
      5'd7:  cw = mul_word(CSEL_B0, SSEL_X, 1'b1);
      5'd8:  cw = mul_word(CSEL_B2, SSEL_XH1, 1'b0);
      5'd9:  cw = mul_word(CSEL_B2, SSEL_XH1, 1'b1);
      5'd10: cw = mul_word(CSEL_B4, SSEL_XH3, 1'b0);
      5'd11: cw = mul_word(CSEL_B4, SSEL_XH3, 1'b1);
      5'd12: cw = mul_word(CSEL_A1, SSEL_YH0, 1'b0);
      5'd13: cw = mul_word(CSEL_A1, SSEL_YH0, 1'b1);
      5'd14: cw = mul_word(CSEL_A2, SSEL_YH1, 1'b0);
      5'd15: cw = mul_word(CSEL_A2, SSEL_YH1, 1'b1);
      5'd16: cw = mul_word(CSEL_A3, SSEL_YH2, 1'b0);
      5'd17: cw = mul_word(CSEL_A3, SSEL_YH2, 1'b1);
      5'd18: cw = mul_word(CSEL_A4, SSEL_YH3, 1'b0);
      5'd19: cw = mul_word(CSEL_A4, SSEL_YH3, 1'b1);
      5'd20: cw = CW_NOP;
      5'd21: cw = act_word(ACT_FINISH, HOLD_NONE, 1'b0);
      5'd22: cw = act_word(ACT_EMIT, HOLD_OUT, 1'b1);
      default: cw = act_word(ACT_NONE, HOLD_NONE, 1'b1);
    endcase
    return cw;
  endfunction

endpackage

// ===== src/ebf_channel_if.sv =====
// Valid/ready channel interfaces for samples in and filtered samples out.
interface ebf_sample_if;
  import ebf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface ebf_result_if;
  import ebf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] filtered_out;
  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface

// ===== src/ecg_baseline_iir_filter_unit.sv =====
// ECG baseline removal and fourth-order IIR filter on one shared 33x25 multiply-accumulate.
// A sample is taken at step 0; its result is loaded into the output register at the last step.
// A new sample is taken only after the whole 23-step microcode program, which runs
//   16 multiplies (2 baseline, 14 filter) through the single multiplier and accumulator.
// The output register frees the result side: a stalled result holds only the last step.
// Reset: synchronous, active high; restores default coefficients, zeroes baseline and history.
module ecg_baseline_iir_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  ebf_sample_if.sink                       sample,
  ebf_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [ebf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ebf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ebf_pkg::*;

  logic signed [TAP_W-1:0]    ff_tap0, ff_tap2, ff_tap4;
  logic signed [TAP_W-1:0]    fb_tap1, fb_tap2, fb_tap3, fb_tap4;
  logic [WEIGHT_W-1:0]        baseline_weight;

  logic [STEP_W-1:0]          step;
  ctrl_t                      cw;
  logic                       adv;
  logic                       out_free;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [BASE_W-1:0]   baseline;
  logic signed [HIST_W-1:0]   xval;
  logic signed [HIST_W-1:0]   xh [4];
  logic signed [HIST_W-1:0]   yh [4];

  logic signed [COEF_W-1:0]   coef;
  logic signed [HIST_W-1:0]   src_val;
  logic signed [OPND_W-1:0]   opnd;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_acc;
  logic                       prod_sh;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_ext;

  logic signed [BASE_W-1:0]   base_new;
  logic signed [HIST_W-1:0]   y_new;
  logic signed [HIST_W:0]     out_rnd;
  logic signed [RESULT_W:0]   out_q;
  logic signed [RESULT_W-1:0] out_sat;

  logic signed [HIST_W-1:0]   start_diff;
  logic signed [HIST_W-1:0]   x_new;

  logic                       out_valid;
  logic signed [RESULT_W-1:0] out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_tap0         <= FF_TAP0_RST;
      ff_tap2         <= FF_TAP2_RST;
      ff_tap4         <= FF_TAP4_RST;
      fb_tap1         <= FB_TAP1_RST;
      fb_tap2         <= FB_TAP2_RST;
      fb_tap3         <= FB_TAP3_RST;
      fb_tap4         <= FB_TAP4_RST;
      baseline_weight <= WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FF_TAP0:         ff_tap0 <= cfg_wdata[TAP_W-1:0];
        CFG_FF_TAP2:         ff_tap2 <= cfg_wdata[TAP_W-1:0];
        CFG_FF_TAP4:         ff_tap4 <= cfg_wdata[TAP_W-1:0];
        CFG_FB_TAP1:         fb_tap1 <= cfg_wdata[TAP_W-1:0];
        CFG_FB_TAP2:         fb_tap2 <= cfg_wdata[TAP_W-1:0];
        CFG_FB_TAP3:         fb_tap3 <= cfg_wdata[TAP_W-1:0];
        CFG_FB_TAP4:         fb_tap4 <= cfg_wdata[TAP_W-1:0];
        CFG_BASELINE_WEIGHT: baseline_weight <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign cw       = ucode(step);
  assign out_free = !out_valid || result.ready;
  assign adv      = !((cw.hold == HOLD_IN) && !sample.valid) &&
                    !((cw.hold == HOLD_OUT) && !out_free);
  assign sample.ready = (cw.hold == HOLD_IN);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (adv) begin
      step <= cw.last ? '0 : step + 1'b1;
    end
  end

  // multiplier operands
  always_comb begin
    case (cw.coef)
      CSEL_WEIGHT: coef = $signed({{(COEF_W-WEIGHT_W){1'b0}}, baseline_weight});
      CSEL_B0:     coef = {ff_tap0[TAP_W-1], ff_tap0};
      CSEL_B2:     coef = {ff_tap2[TAP_W-1], ff_tap2};
      CSEL_B4:     coef = {ff_tap4[TAP_W-1], ff_tap4};
      CSEL_A1:     coef = -{fb_tap1[TAP_W-1], fb_tap1};
      CSEL_A2:     coef = -{fb_tap2[TAP_W-1], fb_tap2};
      CSEL_A3:     coef = -{fb_tap3[TAP_W-1], fb_tap3};
      CSEL_A4:     coef = -{fb_tap4[TAP_W-1], fb_tap4};
      default:     coef = '0;
    endcase
    case (cw.src)
      SSEL_X:   src_val = xval;
      SSEL_XH1: src_val = xh[1];
      SSEL_XH3: src_val = xh[3];
      SSEL_YH0: src_val = yh[0];
      SSEL_YH1: src_val = yh[1];
      SSEL_YH2: src_val = yh[2];
      SSEL_YH3: src_val = yh[3];
      default:  src_val = '0;
    endcase
    opnd = cw.part_hi ? {src_val[HIST_W-1], src_val[HIST_W-1:FRAC_W]}
                      : $signed({{(OPND_W-FRAC_W){1'b0}}, src_val[FRAC_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_acc <= 1'b0;
    end else begin
      prod_acc <= cw.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= coef * opnd;
    prod_sh <= cw.part_hi;
  end

  assign prod_ext = prod_sh ? {prod, {FRAC_W{1'b0}}}
                            : {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // rounding and saturation
  always_comb begin
    if ((&acc[ACC_W-1:BASE_MSB]) || !(|acc[ACC_W-1:BASE_MSB])) begin
      base_new = acc[BASE_MSB:BASE_LSB];
    end else begin
      base_new = acc[ACC_W-1] ? {1'b1, {(BASE_W-1){1'b0}}} : {1'b0, {(BASE_W-1){1'b1}}};
    end
    if ((&acc[ACC_W-1:Y_MSB]) || !(|acc[ACC_W-1:Y_MSB])) begin
      y_new = acc[Y_MSB:Y_LSB];
    end else begin
      y_new = acc[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    out_rnd = {yh[0][HIST_W-1], yh[0]} + (HIST_W+1)'(1 << (OUT_SH-1));
    out_q   = out_rnd[HIST_W:OUT_SH];
    if (out_q[RESULT_W] == out_q[RESULT_W-1]) begin
      out_sat = out_q[RESULT_W-1:0];
    end else begin
      out_sat = out_q[RESULT_W] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                : {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  assign start_diff = {{(HIST_W-SAMPLE_W-FRAC_W){sample.sample_in[SAMPLE_W-1]}},
                       sample.sample_in, {FRAC_W{1'b0}}}
                    - {{(HIST_W-BASE_W){baseline[BASE_W-1]}}, baseline};
  assign x_new      = {{(HIST_W-SAMPLE_W-FRAC_W){sample_q[SAMPLE_W-1]}},
                       sample_q, {FRAC_W{1'b0}}}
                    - {{(HIST_W-BASE_W){baseline[BASE_W-1]}}, baseline};

  // datapath: sample, operand and accumulator
  always_ff @(posedge clk) begin
    if (cw.act == ACT_START && adv) begin
      sample_q <= sample.sample_in;
      xval     <= start_diff;
      acc      <= {{(ACC_W-BASE_W-FRAC_W){baseline[BASE_W-1]}}, baseline, 1'b1,
                   {(FRAC_W-1){1'b0}}};
    end else if (cw.act == ACT_XLOAD) begin
      xval <= x_new;
      acc  <= ACC_W'(1) << (Y_LSB - 1);
    end else if (prod_acc) begin
      acc <= acc + prod_ext;
    end
  end

  // baseline and history
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
      for (int i = 0; i < 4; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      if (cw.act == ACT_BASE) begin
        baseline <= base_new;
      end
      if (cw.act == ACT_FINISH) begin
        for (int i = 3; i > 0; i--) begin
          xh[i] <= xh[i-1];
          yh[i] <= yh[i-1];
        end
        xh[0] <= xval;
        yh[0] <= y_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.act == ACT_EMIT && adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_EMIT && adv) begin
      out_data <= out_sat;
    end
  end

  assign result.valid        = out_valid;
  assign result.filtered_out = out_data;

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("sequencer step beyond program end");

  a_start_to_step1: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (step == 5'd1))
    else $error("sample transfer did not start the program");

  a_no_acc_clash: assert property (@(posedge clk) disable iff (rst)
    !(prod_acc && ((cw.act == ACT_XLOAD) || (cw.act == ACT_START && adv))))
    else $error("accumulate collides with accumulator preload");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cw.act == ACT_EMIT && adv) |=> (out_valid && step == 5'd0))
    else $error("emit step did not load the output register");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> !out_valid || $past(cw.act == ACT_EMIT) || step == 5'd0)
    else $error("sample ready outside the wait step");

endmodule

// ===== dv/ecg_baseline_iir_filter_unit_tb.sv =====
// Self-checking testbench for the ECG baseline removal and fourth-order IIR filter unit.
module ecg_baseline_iir_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ebf_pkg::*;

  typedef logic signed [79:0] acc_t;
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef struct packed {
    row_kind_t          kind;
    cfg_reg_t           idx;
    logic [31:0]        data;
    logic               typed;
    logic signed [31:0] want;
  } dir_row_t;

  localparam longint HIST_HI = (longint'(1) <<< (HIST_W - 1)) - 1;
  localparam longint HIST_LO = -(longint'(1) <<< (HIST_W - 1));
  localparam longint BASE_HI = (longint'(1) <<< (BASE_W - 1)) - 1;
  localparam longint BASE_LO = -(longint'(1) <<< (BASE_W - 1));
  localparam longint OUT_HI  = (longint'(1) <<< (RESULT_W - 1)) - 1;
  localparam longint OUT_LO  = -(longint'(1) <<< (RESULT_W - 1));

  localparam int RING_DEPTH = 16;

  localparam int DIR_ROWS = 40;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_0000, 1'b1, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_0000, 1'b1, 32'sd0},
    '{ROW_WRITE,  CFG_FF_TAP0,         32'h0800_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FF_TAP2,         32'h0000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FF_TAP4,         32'h0000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP1,         32'h0000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP2,         32'h0000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP3,         32'h0000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP4,         32'h0000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_BASELINE_WEIGHT, 32'hABCD_0000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b1, 32'sd8388352},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_8000, 1'b1, -32'sd8388608},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_0001, 1'b1, 32'sd256},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_FFFF, 1'b1, -32'sd256},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_5555, 1'b1, 32'sd5592320},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_AAAA, 1'b1, -32'sd5592576},
    '{ROW_WRITE,  CFG_FF_TAP0,         32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_8000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP1,         32'h8000_0000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FF_TAP0,         32'h8000_0000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_BASELINE_WEIGHT, 32'h0000_FFFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_8000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_7FFF, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FF_TAP2,         32'h8000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FF_TAP4,         32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP2,         32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP3,         32'h8000_0000, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FB_TAP4,         32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_1234, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_EDCB, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FF_TAP0,         32'h0000_0000, 1'b0, 32'sd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ebf_sample_if smp_if ();
  ebf_result_if res_if ();

  ecg_baseline_iir_filter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic signed [TAP_W-1:0] coef_b0, coef_b2, coef_b4;
  logic signed [TAP_W-1:0] coef_a1, coef_a2, coef_a3, coef_a4;
  logic [WEIGHT_W-1:0]     ema_weight;
  longint                  ema_level;
  longint                  x_hist [4];
  longint                  y_hist [4];

  logic signed [RESULT_W-1:0] want_ring [RING_DEPTH];
  int ring_wr;
  int ring_rd;
  int pending_cnt;
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int ecg_trace;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [RESULT_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] s);
    longint scaled, delta, x0, y0;
    acc_t   acc;
    scaled    = longint'(s) <<< FRAC_W;
    delta     = longint'(ema_weight) * (scaled - ema_level);
    ema_level = clamp(ema_level + ((delta + 32768) >>> FRAC_W), BASE_LO, BASE_HI);
    x0        = clamp(scaled - ema_level, HIST_LO, HIST_HI);
    acc = acc_t'(coef_b0) * acc_t'(x0)
        + acc_t'(coef_b2) * acc_t'(x_hist[1])
        + acc_t'(coef_b4) * acc_t'(x_hist[3])
        - acc_t'(coef_a1) * acc_t'(y_hist[0])
        - acc_t'(coef_a2) * acc_t'(y_hist[1])
        - acc_t'(coef_a3) * acc_t'(y_hist[2])
        - acc_t'(coef_a4) * acc_t'(y_hist[3]);
    acc = (acc + (acc_t'(1) <<< 26)) >>> 27;
    y0  = clamp(longint'(acc), HIST_LO, HIST_HI);
    for (int i = 3; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
      y_hist[i] = y_hist[i-1];
    end
    x_hist[0] = x0;
    y_hist[0] = y0;
    return RESULT_W'(clamp((y0 + 128) >>> OUT_SH, OUT_LO, OUT_HI));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int r;
    int spike;
    r = $urandom_range(99);
    if (r < 65) begin
      // slow wander with noise, plus an occasional sharp peak
      ecg_trace = ecg_trace - ecg_trace / 64 + int'($urandom_range(1200)) - 600;
      ecg_trace = int'(clamp(ecg_trace, -20000, 20000));
      spike = ($urandom_range(19) == 0) ? int'($urandom_range(12000)) : 0;
      return SAMPLE_W'(ecg_trace + spike);
    end
    if (r < 88) return SAMPLE_W'($urandom);
    r = $urandom_range(3);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r == 2) return 16'sh0000;
    return 16'shFFFF;
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                             input logic signed [RESULT_W-1:0] want);
    logic signed [RESULT_W-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid     <= 1'b0;
      smp_if.sample_in <= SAMPLE_W'($urandom);
      @(posedge clk);
    end
    smp_if.valid     <= 1'b1;
    smp_if.sample_in <= s;
    do @(posedge clk); while (smp_if.ready !== 1'b1);
    pred = filter_sample(s);
    want_ring[ring_wr] = typed ? want : pred;
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    pending_cnt++;
  endtask

  task automatic drain();
    smp_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_FF_TAP0:         coef_b0 = v;
      CFG_FF_TAP2:         coef_b2 = v;
      CFG_FF_TAP4:         coef_b4 = v;
      CFG_FB_TAP1:         coef_a1 = v;
      CFG_FB_TAP2:         coef_a2 = v;
      CFG_FB_TAP3:         coef_a3 = v;
      CFG_FB_TAP4:         coef_a4 = v;
      CFG_BASELINE_WEIGHT: ema_weight = v[WEIGHT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_phase_taps(input int ph);
    logic [CFG_DATA_W-1:0] v [8];
    v = '{FF_TAP0_RST, FF_TAP2_RST, FF_TAP4_RST, FB_TAP1_RST, FB_TAP2_RST,
          FB_TAP3_RST, FB_TAP4_RST, CFG_DATA_W'(WEIGHT_RST)};
    case (ph)
      1: begin
        for (int i = 0; i < 7; i++) v[i] = $urandom_range(32'h1000_0000) - 32'h0800_0000;
        v[7] = $urandom_range(16'hFFFF);
      end
      2: v[7] = 32'h0000_FFFF;
      3: foreach (v[i]) v[i] = $urandom;
      4: begin
        foreach (v[i]) v[i] = 32'h7FFF_FFFF;
        v[7] = 32'hFFFF_FFFF;
      end
      5: begin
        foreach (v[i]) v[i] = 32'h8000_0000;
        v[7] = 32'h0000_0000;
      end
      7: v[7] = $urandom;
      default: ;
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(CFG_IDX_W'(i)), v[i]);
    cfg_we <= 1'b0;
  endtask

  task automatic check_result(input logic signed [RESULT_W-1:0] got);
    logic signed [RESULT_W-1:0] want;
    if (pending_cnt == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected filtered_out %0d", got);
    end else begin
      want = want_ring[ring_rd];
      ring_rd = (ring_rd + 1) % RING_DEPTH;
      pending_cnt--;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: filtered_out expected %0d got %0d", want, got);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    res_if.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_result(res_if.filtered_out);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    coef_b0        = FF_TAP0_RST;
    coef_b2        = FF_TAP2_RST;
    coef_b4        = FF_TAP4_RST;
    coef_a1        = FB_TAP1_RST;
    coef_a2        = FB_TAP2_RST;
    coef_a3        = FB_TAP3_RST;
    coef_a4        = FB_TAP4_RST;
    ema_weight     = WEIGHT_RST;
    ema_level      = 0;
    x_hist         = '{0, 0, 0, 0};
    y_hist         = '{0, 0, 0, 0};
    ring_wr        = 0;
    ring_rd        = 0;
    pending_cnt    = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    ecg_trace      = 0;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_FF_TAP0;
    cfg_wdata        <= '0;
    smp_if.valid     <= 1'b0;
    smp_if.sample_in <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TBL[i]) begin
      if (DIR_TBL[i].kind == ROW_WRITE) begin
        drain();
        write_reg(DIR_TBL[i].idx, DIR_TBL[i].data);
        cfg_we <= 1'b0;
      end else begin
        push_sample(DIR_TBL[i].data[SAMPLE_W-1:0], DIR_TBL[i].typed, DIR_TBL[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      load_phase_taps(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < 106; n++) begin
        // hold the result side off while samples keep coming, then pause the sender
        if (ph == 6 && n == 0) hold_left = 300;
        if (ph == 6 && n == 60) drain();
        push_sample(next_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
